// ===== hw/rtl/sgf_pkg.sv =====
package sgf_pkg;

   // channel lanes that are built, and channel ports on the word
   localparam int CHANNELS = 8;
   localparam int PORT_CH  = 8;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 18;
   localparam int FADE_W   = 17;
   localparam int COEF_W   = 16;
   localparam int CNT_W    = 4;
   // gain * fade rounded to Q.16 stays below 2^19
   localparam int COMB_W   = 19;

   // csr register map
   localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd0;
   localparam logic [1:0] REG_SMOOTHING_COEF  = 2'd1;
   localparam logic [1:0] REG_FADE_STEP       = 2'd2;
   localparam logic [1:0] REG_GAIN_EPSILON    = 2'd3;

   // how the lanes treat their sample
   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_ZERO  = 2'd1;
   localparam logic [1:0] MODE_SCALE = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // gain control to lanes
   typedef struct packed {
      logic [1:0]        mode;
      logic [COMB_W-1:0] combined;
   } scale_type;

   // sequencer step strobes to the gain control
   typedef struct packed {
      logic flag_en;
      logic update_en;
      logic comb_en;
      logic mode_en;
   } step_type;

endpackage

// ===== hw/rtl/sgf_lane.sv =====
module sgf_lane import sgf_pkg::*; (
   input  logic       clock,
   input  logic       load_en,
   input  sample_type sample,
   input  logic       lane_on,
   input  scale_type  scale,
   output sample_type result
);

   localparam int PROD_W  = SAMPLE_W + COMB_W + 1;
   localparam int ROUND_W = PROD_W - 16;
   localparam logic signed [ROUND_W-1:0] SAT_HI = ROUND_W'((2 ** (SAMPLE_W - 1)) - 1);
   localparam logic signed [ROUND_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  biased;
   logic signed [ROUND_W-1:0] rounded;
   sample_type                sat_val;

   // sample times combined gain, registered
   assign prod_in = sample * $signed({1'b0, scale.combined});

   always_ff @(posedge clock) begin
      if (load_en) begin
         prod_ff <= prod_in;
      end
   end

   // round to nearest at Q1.23, ties up, then saturate
   assign biased  = prod_ff + PROD_W'(32768);
   assign rounded = biased[PROD_W-1:16];

   always_comb begin
      if (rounded > SAT_HI) begin
         sat_val = SAT_HI[SAMPLE_W-1:0];
      end else if (rounded < SAT_LO) begin
         sat_val = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sat_val = rounded[SAMPLE_W-1:0];
      end
   end

   // lane output select
   always_comb begin
      if (!lane_on) begin
         result = '0;
      end else begin
         case (scale.mode)
            MODE_PASS:  result = sample;
            MODE_ZERO:  result = '0;
            MODE_SCALE: result = sat_val;
            default:    result = '0;
         endcase
      end
   end

endmodule

// ===== hw/rtl/sgf_ctrl.sv =====
module sgf_ctrl import sgf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step,
   input  logic              first_in_block,
   input  logic [GAIN_W-1:0] target_gain,
   input  logic [FADE_W-1:0] target_fade,
   input  logic [COEF_W-1:0] smoothing_coef,
   input  logic [COEF_W-1:0] fade_step,
   input  logic [COEF_W-1:0] gain_epsilon,
   output scale_type         scale,
   output logic [GAIN_W-1:0] gain_now,
   output logic [FADE_W-1:0] fade_now
);

   localparam int SMOOTH_W = GAIN_W + COEF_W + 2;
   localparam int RND_W    = SMOOTH_W - 16;
   localparam int SUM_W    = GAIN_W + 3;
   localparam int GF_W     = GAIN_W + FADE_W;
   localparam logic [COMB_W-1:0] UNITY = COMB_W'(65536);

   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic [FADE_W-1:0]         fade_ff, fade_in;
   logic                      gain_settled_ff, gain_settled_in;
   logic                      fade_settled_ff, fade_settled_in;
   logic signed [SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [COMB_W-1:0]         comb_ff, comb_in;
   logic [1:0]                mode_ff, mode_in;

   logic signed [GAIN_W:0]     diff;
   logic signed [SMOOTH_W-1:0] smooth_biased;
   logic signed [RND_W-1:0]    smooth_rnd;
   logic signed [SUM_W-1:0]    gain_sum;
   logic [GAIN_W-1:0]          gain_clamp;
   logic [FADE_W-1:0]          fade_ramp;
   logic [FADE_W-1:0]          step_ext;
   logic [GF_W-1:0]            gf_sum;
   logic                       both_settled;

   function automatic logic near_fn(input logic [COMB_W-1:0] a,
                                    input logic [COMB_W-1:0] b,
                                    input logic [COEF_W-1:0] eps);
      logic [COMB_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      return d <= COMB_W'(eps);
   endfunction

   assign both_settled = gain_settled_ff & fade_settled_ff;

   // smoother product: (target - gain) * coef
   assign diff      = $signed({1'b0, target_gain}) - $signed({1'b0, gain_ff});
   assign smooth_in = diff * $signed({1'b0, smoothing_coef});

   // rounded smoother step added to gain, clamped to range
   assign smooth_biased = smooth_ff + SMOOTH_W'(32768);
   assign smooth_rnd    = smooth_biased[SMOOTH_W-1:16];
   assign gain_sum      = $signed({3'b000, gain_ff}) + SUM_W'(smooth_rnd);

   always_comb begin
      if (gain_sum[SUM_W-1]) begin
         gain_clamp = '0;
      end else if (|gain_sum[SUM_W-2:GAIN_W]) begin
         gain_clamp = '1;
      end else begin
         gain_clamp = gain_sum[GAIN_W-1:0];
      end
   end

   // linear fade ramp, stops at target
   assign step_ext = FADE_W'(fade_step);

   always_comb begin
      fade_ramp = fade_ff;
      if (fade_ff > target_fade) begin
         if (fade_ff - target_fade > step_ext) begin
            fade_ramp = fade_ff - step_ext;
         end else begin
            fade_ramp = target_fade;
         end
      end else if (fade_ff < target_fade) begin
         if (target_fade - fade_ff > step_ext) begin
            fade_ramp = fade_ff + step_ext;
         end else begin
            fade_ramp = target_fade;
         end
      end
   end

   // combined gain, rounded to Q.16
   assign gf_sum  = (GF_W'(gain_ff) * GF_W'(fade_ff)) + GF_W'(32768);
   assign comb_in = gf_sum[GF_W-1:16];

   // state next values per step
   always_comb begin
      gain_in         = gain_ff;
      fade_in         = fade_ff;
      gain_settled_in = gain_settled_ff;
      fade_settled_in = fade_settled_ff;
      if (step.flag_en && first_in_block) begin
         gain_settled_in = near_fn(COMB_W'(gain_ff), COMB_W'(target_gain), gain_epsilon);
         fade_settled_in = near_fn(COMB_W'(fade_ff), COMB_W'(target_fade), gain_epsilon);
      end
      if (step.update_en) begin
         if (both_settled) begin
            gain_in = target_gain;
            fade_in = target_fade;
         end else begin
            if (!gain_settled_ff) begin
               gain_in = gain_clamp;
            end
            if (!fade_settled_ff) begin
               fade_in = fade_ramp;
            end
         end
      end
   end

   // lane mode
   always_comb begin
      if (!both_settled) begin
         mode_in = MODE_SCALE;
      end else if (near_fn(comb_ff, UNITY, gain_epsilon)) begin
         mode_in = MODE_PASS;
      end else if (comb_ff <= COMB_W'(gain_epsilon)) begin
         mode_in = MODE_ZERO;
      end else begin
         mode_in = MODE_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff         <= GAIN_W'(65536);
         fade_ff         <= FADE_W'(65536);
         gain_settled_ff <= 1'b1;
         fade_settled_ff <= 1'b1;
      end else begin
         gain_ff         <= gain_in;
         fade_ff         <= fade_in;
         gain_settled_ff <= gain_settled_in;
         fade_settled_ff <= fade_settled_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (step.flag_en) begin
         smooth_ff <= smooth_in;
      end
      if (step.comb_en) begin
         comb_ff <= comb_in;
      end
      if (step.mode_en) begin
         mode_ff <= mode_in;
      end
   end

   assign scale.mode     = mode_ff;
   assign scale.combined = comb_ff;
   assign gain_now       = gain_ff;
   assign fade_now       = fade_ff;

endmodule

// ===== hw/rtl/smoothed_gain_and_fade.sv =====
// Gain and fade stage for one audio frame of up to eight Q1.23 samples. A
// sequencer takes one accepted word at a time and accepts the next frame only
// once that one has reached the result register, which waits while an earlier
// result there has not been taken. It steps the one shared gain control
// through the stability check with the smoother multiply, the gain/fade update,
// the gain-times-fade multiply and the lane mode choice, which goes together
// with the eight channel lanes' multiply, then the lanes' rounding into the
// result register. A finished result waits in the output register while the
// next frame is already being taken. Registers must be written through the csr
// port only while no frame is in flight; the block itself does not enforce this.
module smoothed_gain_and_fade import sgf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_ready,
   input  sample_type        req_sample_0,
   input  sample_type        req_sample_1,
   input  sample_type        req_sample_2,
   input  sample_type        req_sample_3,
   input  sample_type        req_sample_4,
   input  sample_type        req_sample_5,
   input  sample_type        req_sample_6,
   input  sample_type        req_sample_7,
   input  logic [GAIN_W-1:0] req_target_gain,
   input  logic [FADE_W-1:0] req_target_fade,
   input  logic              req_first_in_block,
   // result words
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sample_type        rsp_out_0,
   output sample_type        rsp_out_1,
   output sample_type        rsp_out_2,
   output sample_type        rsp_out_3,
   output sample_type        rsp_out_4,
   output sample_type        rsp_out_5,
   output sample_type        rsp_out_6,
   output sample_type        rsp_out_7,
   output logic [GAIN_W-1:0] rsp_gain_now,
   output logic [FADE_W-1:0] rsp_fade_now,
   // register writes
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [COEF_W-1:0] csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FLAG = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_COMB = 3'd3;
   localparam logic [2:0] ST_MODE = 3'd4;
   localparam logic [2:0] ST_LANE = 3'd5;

   localparam logic [CNT_W-1:0] CH_MAX = CNT_W'(CHANNELS);

   logic [2:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   active_ff;
   logic [COEF_W-1:0]  coef_ff;
   logic [COEF_W-1:0]  step_ff;
   logic [COEF_W-1:0]  eps_ff;

   sample_type         req_sample [PORT_CH];
   sample_type         sample_ff [PORT_CH];
   logic [GAIN_W-1:0]  target_gain_ff;
   logic [FADE_W-1:0]  target_fade_ff;
   logic               first_ff;

   sample_type         lane_res [PORT_CH];
   sample_type         out_ff [PORT_CH];
   logic [GAIN_W-1:0]  gain_out_ff;
   logic [FADE_W-1:0]  fade_out_ff;

   logic               accept;
   logic               out_load;
   logic [CNT_W-1:0]   n_active;
   step_type           step;
   scale_type          scale;
   logic [GAIN_W-1:0]  gain_now;
   logic [FADE_W-1:0]  fade_now;

   assign req_sample[0] = req_sample_0;
   assign req_sample[1] = req_sample_1;
   assign req_sample[2] = req_sample_2;
   assign req_sample[3] = req_sample_3;
   assign req_sample[4] = req_sample_4;
   assign req_sample[5] = req_sample_5;
   assign req_sample[6] = req_sample_6;
   assign req_sample[7] = req_sample_7;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CNT_W'(2);
         coef_ff   <= COEF_W'(1000);
         step_ff   <= COEF_W'(7);
         eps_ff    <= COEF_W'(7);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_ACTIVE_CHANNELS: active_ff <= csr_write_data[CNT_W-1:0];
            REG_SMOOTHING_COEF:  coef_ff   <= csr_write_data;
            REG_FADE_STEP:       step_ff   <= csr_write_data;
            REG_GAIN_EPSILON:    eps_ff    <= csr_write_data;
            default:             active_ff <= active_ff;
         endcase
      end
   end

   assign n_active = (active_ff > CH_MAX) ? CH_MAX : active_ff;

   // sequencer
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_load  = (state_ff == ST_LANE) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            state_in = ST_FLAG;
         end
         ST_FLAG: state_in = ST_UPD;
         ST_UPD:  state_in = ST_COMB;
         ST_COMB: state_in = ST_MODE;
         ST_MODE: state_in = ST_LANE;
         ST_LANE: if (out_load) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign step.flag_en   = (state_ff == ST_FLAG);
   assign step.update_en = (state_ff == ST_UPD);
   assign step.comb_en   = (state_ff == ST_COMB);
   assign step.mode_en   = (state_ff == ST_MODE);

   // input word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int c = 0; c < PORT_CH; c++) begin
            sample_ff[c] <= req_sample[c];
         end
         target_gain_ff <= req_target_gain;
         target_fade_ff <= req_target_fade;
         first_ff       <= req_first_in_block;
      end
   end

   // shared gain and fade control
   sgf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .first_in_block (first_ff),
      .target_gain    (target_gain_ff),
      .target_fade    (target_fade_ff),
      .smoothing_coef (coef_ff),
      .fade_step      (step_ff),
      .gain_epsilon   (eps_ff),
      .scale          (scale),
      .gain_now       (gain_now),
      .fade_now       (fade_now)
   );

   // channel lanes
   for (genvar c = 0; c < PORT_CH; c++) begin : g_lane
      if (c < CHANNELS) begin : g_on
         sgf_lane u_lane (
            .clock   (clock),
            .load_en (step.mode_en),
            .sample  (sample_ff[c]),
            .lane_on (CNT_W'(c) < n_active),
            .scale   (scale),
            .result  (lane_res[c])
         );
      end else begin : g_off
         assign lane_res[c] = '0;
      end
   end

   // merge lane results and gain state into the result word
   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int c = 0; c < PORT_CH; c++) begin
            out_ff[c] <= lane_res[c];
         end
         gain_out_ff <= gain_now;
         fade_out_ff <= fade_now;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_0    = out_ff[0];
   assign rsp_out_1    = out_ff[1];
   assign rsp_out_2    = out_ff[2];
   assign rsp_out_3    = out_ff[3];
   assign rsp_out_4    = out_ff[4];
   assign rsp_out_5    = out_ff[5];
   assign rsp_out_6    = out_ff[6];
   assign rsp_out_7    = out_ff[7];
   assign rsp_gain_now = gain_out_ff;
   assign rsp_fade_now = fade_out_ff;

endmodule

// ===== hw/rtl/sgf_checker.sv =====
module sgf_checker import sgf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sample_type        rsp_out_0,
   input logic [GAIN_W-1:0] rsp_gain_now,
   input logic [FADE_W-1:0] rsp_fade_now
);

   // out of reset: nothing to deliver, ready for a word
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or not ready after reset");

   // one frame at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a frame is in flight");

   // a new result only comes out of a busy cycle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a frame in flight");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_0)
         && $stable(rsp_gain_now) && $stable(rsp_fade_now))
      else $error("stalled result word changed");

endmodule

bind smoothed_gain_and_fade sgf_checker u_sgf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_0    (rsp_out_0),
   .rsp_gain_now (rsp_gain_now),
   .rsp_fade_now (rsp_fade_now)
);

// ===== verif/sgf_frame_checker.sv =====
`timescale 1ns / 100ps

package sgf_bench_pkg;
   import sgf_pkg::*;

   // one input frame as carried by the request word
   typedef struct packed {
      sample_type [PORT_CH-1:0] samples;
      logic [GAIN_W-1:0]        target_gain;
      logic [FADE_W-1:0]        target_fade;
      logic                     first_in_block;
   } frame_word_type;

   // one scaled frame as carried by the result word
   typedef struct packed {
      sample_type [PORT_CH-1:0] outs;
      logic [GAIN_W-1:0]        gain_now;
      logic [FADE_W-1:0]        fade_now;
   } scaled_word_type;
endpackage

module sgf_frame_checker import sgf_pkg::*, sgf_bench_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  sample_type        req_sample_0,
   input  sample_type        req_sample_1,
   input  sample_type        req_sample_2,
   input  sample_type        req_sample_3,
   input  sample_type        req_sample_4,
   input  sample_type        req_sample_5,
   input  sample_type        req_sample_6,
   input  sample_type        req_sample_7,
   input  logic [GAIN_W-1:0] req_target_gain,
   input  logic [FADE_W-1:0] req_target_fade,
   input  logic              req_first_in_block,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  sample_type        rsp_out_0,
   input  sample_type        rsp_out_1,
   input  sample_type        rsp_out_2,
   input  sample_type        rsp_out_3,
   input  sample_type        rsp_out_4,
   input  sample_type        rsp_out_5,
   input  sample_type        rsp_out_6,
   input  sample_type        rsp_out_7,
   input  logic [GAIN_W-1:0] rsp_gain_now,
   input  logic [FADE_W-1:0] rsp_fade_now,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [COEF_W-1:0] csr_write_data,
   output int                mismatch_count,
   output int                words_pending,
   output int                words_checked
);

   // register copies
   logic [CNT_W-1:0]  chan_count;
   logic [COEF_W-1:0] coef;
   logic [COEF_W-1:0] ramp_step;
   logic [COEF_W-1:0] epsilon;

   // gain control state
   logic [GAIN_W-1:0] gain_q;
   logic [FADE_W-1:0] fade_q;
   logic              gain_steady;
   logic              fade_steady;

   scaled_word_type scaled_q[$];
   int              fail_total;

   assign mismatch_count = fail_total;

   function automatic logic is_near(longint unsigned a, longint unsigned b);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      return d <= epsilon;
   endfunction

   // x / 2^16, rounded to nearest with ties toward +inf
   function automatic longint round_q16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // advance the gain control by one frame and scale its samples
   function automatic scaled_word_type apply_gain_and_fade(frame_word_type f);
      scaled_word_type res;
      longint          comb;
      longint          g;
      longint          s;
      longint          r;
      int              lanes;
      logic [1:0]      lane_mode;
      lanes = (chan_count > CHANNELS) ? CHANNELS : int'(chan_count);
      if (f.first_in_block) begin
         gain_steady = is_near(gain_q, f.target_gain);
         fade_steady = is_near(fade_q, f.target_fade);
      end
      if (gain_steady && fade_steady) begin
         // both settled: snap and pick pass / zero / scale
         gain_q = f.target_gain;
         fade_q = f.target_fade;
         comb = (longint'(gain_q) * longint'(fade_q) + 32768) >>> 16;
         if (is_near(comb, 65536))
            lane_mode = MODE_PASS;
         else if (comb <= longint'(epsilon))
            lane_mode = MODE_ZERO;
         else
            lane_mode = MODE_SCALE;
      end else begin
         // one-pole smoother on gain
         if (!gain_steady) begin
            g = longint'(gain_q) + round_q16((longint'(f.target_gain) - longint'(gain_q))
                                             * longint'(coef));
            if (g < 0) g = 0;
            if (g > 262143) g = 262143;
            gain_q = g[GAIN_W-1:0];
         end
         // linear fade ramp, clamped at the target
         if (!fade_steady && fade_q != f.target_fade) begin
            if (fade_q > f.target_fade)
               fade_q = (fade_q - f.target_fade > ramp_step) ? fade_q - ramp_step
                                                             : f.target_fade;
            else
               fade_q = (f.target_fade - fade_q > ramp_step) ? fade_q + ramp_step
                                                             : f.target_fade;
         end
         comb = (longint'(gain_q) * longint'(fade_q) + 32768) >>> 16;
         lane_mode = MODE_SCALE;
      end
      for (int c = 0; c < PORT_CH; c++) begin
         s = longint'($signed(f.samples[c]));
         if (c >= lanes)
            r = 0;
         else if (lane_mode == MODE_PASS)
            r = s;
         else if (lane_mode == MODE_ZERO)
            r = 0;
         else begin
            r = round_q16(s * comb);
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
         end
         res.outs[c] = r[SAMPLE_W-1:0];
      end
      res.gain_now = gain_q;
      res.fade_now = fade_q;
      return res;
   endfunction

   task automatic note_mismatch(string name, logic [31:0] want, logic [31:0] got);
      fail_total++;
      if (fail_total <= 10)
         $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
   endtask

   always @(posedge clock) begin : watch
      frame_word_type  seen_req;
      scaled_word_type seen_rsp;
      scaled_word_type want;
      if (reset) begin
         chan_count  = 4'd2;
         coef        = 16'd1000;
         ramp_step   = 16'd7;
         epsilon     = 16'd7;
         gain_q      = 18'd65536;
         fade_q      = 17'd65536;
         gain_steady = 1'b1;
         fade_steady = 1'b1;
         scaled_q.delete();
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               REG_ACTIVE_CHANNELS: chan_count = csr_write_data[CNT_W-1:0];
               REG_SMOOTHING_COEF:  coef       = csr_write_data;
               REG_FADE_STEP:       ramp_step  = csr_write_data;
               REG_GAIN_EPSILON:    epsilon    = csr_write_data;
               default: ;
            endcase
         end
         // result words against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            seen_rsp.outs = {rsp_out_7, rsp_out_6, rsp_out_5, rsp_out_4,
                             rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0};
            seen_rsp.gain_now = rsp_gain_now;
            seen_rsp.fade_now = rsp_fade_now;
            words_checked <= words_checked + 1;
            if (scaled_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t result word with nothing expected", $realtime);
            end else begin
               want = scaled_q.pop_front();
               for (int c = 0; c < PORT_CH; c++)
                  if (seen_rsp.outs[c] !== want.outs[c])
                     note_mismatch($sformatf("out_%0d", c), 32'(want.outs[c]),
                                   32'(seen_rsp.outs[c]));
               if (seen_rsp.gain_now !== want.gain_now)
                  note_mismatch("gain_now", 32'(want.gain_now), 32'(seen_rsp.gain_now));
               if (seen_rsp.fade_now !== want.fade_now)
                  note_mismatch("fade_now", 32'(want.fade_now), 32'(seen_rsp.fade_now));
            end
         end
         // accepted frames
         if (req_valid && req_ready) begin
            seen_req.samples = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                                req_sample_3, req_sample_2, req_sample_1, req_sample_0};
            seen_req.target_gain    = req_target_gain;
            seen_req.target_fade    = req_target_fade;
            seen_req.first_in_block = req_first_in_block;
            scaled_q.push_back(apply_gain_and_fade(seen_req));
         end
      end
      words_pending <= scaled_q.size();
   end

endmodule

// ===== verif/smoothed_gain_and_fade_test.sv =====
`timescale 1ns / 100ps

module smoothed_gain_and_fade_test import sgf_pkg::*, sgf_bench_pkg::*;;

   localparam int         LIMIT_CYCLES = 200000;
   localparam sample_type SAMPLE_MAX   = 24'sh7FFFFF;
   localparam sample_type SAMPLE_MIN   = 24'sh800000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   frame_word_type    req_word = '0;
   sample_type        req_sample_0, req_sample_1, req_sample_2, req_sample_3;
   sample_type        req_sample_4, req_sample_5, req_sample_6, req_sample_7;
   logic [GAIN_W-1:0] req_target_gain;
   logic [FADE_W-1:0] req_target_fade;
   logic              req_first_in_block;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sample_type        rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3;
   sample_type        rsp_out_4, rsp_out_5, rsp_out_6, rsp_out_7;
   logic [GAIN_W-1:0] rsp_gain_now;
   logic [FADE_W-1:0] rsp_fade_now;
   logic              csr_write_en = 1'b0;
   logic [1:0]        csr_index = REG_ACTIVE_CHANNELS;
   logic [COEF_W-1:0] csr_write_data = '0;

   int   mismatch_count;
   int   words_pending;
   int   words_checked;
   int   cycles = 0;
   int   frames_sent = 0;
   int   blocks_sent = 0;
   int   settings_used = 0;
   logic calm = 1'b0;

   // request word fans out to the field ports
   assign req_sample_0       = req_word.samples[0];
   assign req_sample_1       = req_word.samples[1];
   assign req_sample_2       = req_word.samples[2];
   assign req_sample_3       = req_word.samples[3];
   assign req_sample_4       = req_word.samples[4];
   assign req_sample_5       = req_word.samples[5];
   assign req_sample_6       = req_word.samples[6];
   assign req_sample_7       = req_word.samples[7];
   assign req_target_gain    = req_word.target_gain;
   assign req_target_fade    = req_word.target_fade;
   assign req_first_in_block = req_word.first_in_block;

   smoothed_gain_and_fade i_dut (.*);

   sgf_frame_checker i_checker (.*);

   always #5 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 15);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words still expected", cycles, words_pending);
         $display("[smoothed_gain_and_fade] ERROR");
         $finish;
      end
   end

   function automatic frame_word_type make_frame(logic [GAIN_W-1:0] tg,
                                                 logic [FADE_W-1:0] tf,
                                                 logic first, logic extreme);
      frame_word_type f;
      for (int c = 0; c < PORT_CH; c++) begin
         if (extreme)
            f.samples[c] = (c % 4 == 0) ? SAMPLE_MAX : (c % 4 == 1) ? SAMPLE_MIN :
                           (c % 4 == 2) ? -24'sd1 : 24'sd1;
         else begin
            case ($urandom_range(7))
               0:       f.samples[c] = SAMPLE_MAX;
               1:       f.samples[c] = SAMPLE_MIN;
               2:       f.samples[c] = '0;
               default: f.samples[c] = sample_type'($urandom);
            endcase
         end
      end
      f.target_gain    = tg;
      f.target_fade    = tf;
      f.first_in_block = first;
      return f;
   endfunction

   // present one word, at times with a random gap ahead of it, and wait for the accept
   task automatic send_word(frame_word_type f);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 15)
         gap = $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= f;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
   endtask

   task automatic send_fixed(logic [GAIN_W-1:0] tg, logic [FADE_W-1:0] tf, logic first);
      send_word(make_frame(tg, tf, first, 1'b1));
   endtask

   // stop sending and let every expected word come back
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_settings(logic [COEF_W-1:0] act, logic [COEF_W-1:0] smooth,
                                logic [COEF_W-1:0] step, logic [COEF_W-1:0] eps);
      csr_write_en   <= 1'b1;
      csr_index      <= REG_ACTIVE_CHANNELS;
      csr_write_data <= act;
      @(posedge clock);
      csr_index      <= REG_SMOOTHING_COEF;
      csr_write_data <= smooth;
      @(posedge clock);
      csr_index      <= REG_FADE_STEP;
      csr_write_data <= step;
      @(posedge clock);
      csr_index      <= REG_GAIN_EPSILON;
      csr_write_data <= eps;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      settings_used++;
   endtask

   // random blocks under one register setting, mostly well formed
   task automatic run_phase(logic [COEF_W-1:0] act, logic [COEF_W-1:0] smooth,
                            logic [COEF_W-1:0] step, logic [COEF_W-1:0] eps,
                            logic quiet, int count);
      int                sent;
      int                len;
      logic [GAIN_W-1:0] tg;
      logic [FADE_W-1:0] tf;
      frame_word_type    f;
      sent = 0;
      tg   = 18'd65536;
      tf   = 17'd65536;
      load_settings(act, smooth, step, eps);
      calm <= quiet;
      while (sent < count) begin
         // new block targets; keeping the old ones lets the block settle
         case ($urandom_range(9))
            0, 1, 2: ;
            3, 4: begin
               tg = 18'd65536;
               tf = 17'd65536;
            end
            5: begin
               tg = ($urandom_range(1) == 1) ? 18'd0 : tg;
               tf = ($urandom_range(1) == 1) ? 17'd0 : 17'd65536;
            end
            6, 7, 8: begin
               tg = GAIN_W'($urandom_range(262143));
               tf = FADE_W'($urandom_range(65536));
            end
            default: begin
               tg = GAIN_W'($urandom_range(131072));
               tf = FADE_W'($urandom_range(131071, 65537));
            end
         endcase
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
         blocks_sent++;
         for (int i = 0; i < len && sent < count; i++) begin
            f = make_frame(tg, tf, i == 0, 1'b0);
            // noise: stray block marks and targets that move inside a block
            if ($urandom_range(9) == 0) begin
               f.first_in_block = 1'($urandom_range(1));
               f.target_gain    = GAIN_W'($urandom);
               f.target_fade    = FADE_W'($urandom);
            end
            send_word(f);
            sent++;
         end
      end
      drain();
      calm <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values; no block started yet
      send_fixed(18'd65536, 17'd65536, 1'b0);
      send_fixed(18'd262143, 17'd65536, 1'b0);
      send_fixed(18'd0, 17'd0, 1'b0);
      send_fixed(18'd0, 17'd0, 1'b1);
      send_fixed(18'd65536, 17'd65536, 1'b0);
      send_fixed(18'd1000, 17'd50000, 1'b0);
      send_fixed(18'd262143, 17'd0, 1'b1);
      repeat (3) send_fixed(18'd262143, 17'd0, 1'b0);
      // fade target above unity
      send_fixed(18'd65536, 17'd131071, 1'b1);
      send_fixed(18'd65536, 17'd131071, 1'b0);
      drain();

      // directed, all channels, fastest smoother and ramp
      load_settings(16'd8, 16'd65535, 16'd65535, 16'd7);
      calm <= 1'b1;
      send_fixed(18'd65536, 17'd65536, 1'b1);
      send_fixed(18'd65536, 17'd65536, 1'b1);
      send_fixed(18'd65536, 17'd65536, 1'b1);
      send_fixed(18'd0, 17'd65536, 1'b1);
      send_fixed(18'd0, 17'd65536, 1'b0);
      send_fixed(18'd0, 17'd65536, 1'b1);
      send_fixed(18'd262143, 17'd131071, 1'b1);
      send_fixed(18'd262143, 17'd131071, 1'b0);
      send_fixed(18'd262143, 17'd131071, 1'b1);
      send_fixed(18'd65536, 17'd0, 1'b1);
      send_fixed(18'd65536, 17'd0, 1'b0);
      send_fixed(18'd65536, 17'd0, 1'b1);
      drain();
      calm <= 1'b0;

      // random phases, extremes of every register among them
      run_phase(16'd8, 16'd1000, 16'd7, 16'd7, 1'b0, 90);
      run_phase(16'd1, 16'd65535, 16'd65535, 16'd0, 1'b0, 90);
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 60);
      run_phase(16'd15, 16'd40000, 16'd3000, 16'd65535, 1'b0, 90);
      run_phase(16'd8, 16'd30000, 16'd500, 16'd300, 1'b1, 90);
      run_phase(16'd5, 16'd65535, 16'd65535, 16'd20, 1'b0, 90);
      run_phase(16'd3, 16'd8000, 16'd2000, 16'd100, 1'b0, 90);

      $display("%0d frames in %0d blocks under %0d register settings, %0d results compared",
               frames_sent, blocks_sent, settings_used, words_checked);
      $display("covered pass, zero and scale paths, smoothing, fade ramps and idle channels");
      if (mismatch_count == 0 && words_pending == 0)
         $display("[smoothed_gain_and_fade] OK");
      else
         $display("[smoothed_gain_and_fade] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sgf_pkg.sv
hw/rtl/sgf_lane.sv
hw/rtl/sgf_ctrl.sv
hw/rtl/smoothed_gain_and_fade.sv
hw/rtl/sgf_checker.sv
verif/sgf_frame_checker.sv
verif/smoothed_gain_and_fade_test.sv
